### rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define NFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define NFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/nfd_pkg.sv
// Package: phase and status codes, result record and packing widths of the deframer.
package nfd_pkg;

    // Parse phases
    localparam logic [2:0] PH_HUNT0  = 3'd0;
    localparam logic [2:0] PH_HUNTFF = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_LCS    = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_DCS    = 3'd5;
    localparam logic [2:0] PH_POST   = 3'd6;

    // Frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ACK      = 3'd1;
    localparam logic [2:0] ST_LCS_ERR  = 3'd2;
    localparam logic [2:0] ST_DCS_ERR  = 3'd3;
    localparam logic [2:0] ST_POST_ERR = 3'd4;

    // Frame marker bytes
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_FF   = 8'hff;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // One result beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [7:0] frame_type;
        logic [7:0] command;
        logic       frame_done;
        logic [2:0] status;
    } t_result;

endpackage

### rtl/nfd_in_reg.sv
// Input register stage of the deframer.
module nfd_in_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [nfd_pkg::IN_TDATA_W-1:0]   i_byte,
    input  logic                             i_adv,     // downstream takes the held beat
    output logic                             o_valid,
    output logic [nfd_pkg::IN_TDATA_W-1:0]   o_byte
);

    logic                           r_valid;
    logic [nfd_pkg::IN_TDATA_W-1:0] r_byte;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Held byte
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

### rtl/nfd_parser.sv
// Frame parser: phase state and the per-byte next-state and result logic.
module nfd_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,   // a byte is processed this cycle
    input  logic [7:0]             i_byte,
    output nfd_pkg::t_result       o_res
);

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_left,  n_left;
    logic [7:0] r_sum,   n_sum;
    logic [7:0] r_tfi,   n_tfi;
    logic [7:0] r_cmd,   n_cmd;
    logic [7:0] body_pos;
    logic [7:0] dcs_sum;

    assign body_pos = r_len - r_left;
    assign dcs_sum  = r_sum + i_byte;

    // Next state and result for one byte
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_left  = r_left;
        n_sum   = r_sum;
        n_tfi   = r_tfi;
        n_cmd   = r_cmd;
        o_res   = '0;
        unique case (r_phase)
            nfd_pkg::PH_HUNTFF: begin
                if (i_byte == nfd_pkg::BYTE_FF) begin
                    n_phase = nfd_pkg::PH_LEN;
                    n_tfi   = '0;
                    n_cmd   = '0;
                    n_sum   = '0;
                end else if (i_byte == nfd_pkg::BYTE_ZERO) begin
                    n_phase = nfd_pkg::PH_HUNTFF;
                end else begin
                    n_phase = nfd_pkg::PH_HUNT0;
                end
            end
            nfd_pkg::PH_LEN: begin
                n_len   = i_byte;
                n_phase = nfd_pkg::PH_LCS;
            end
            nfd_pkg::PH_LCS: begin
                if (r_len == nfd_pkg::BYTE_ZERO && i_byte == nfd_pkg::BYTE_FF) begin
                    o_res.frame_done = 1'b1;
                    o_res.status     = nfd_pkg::ST_ACK;
                    n_phase          = nfd_pkg::PH_HUNT0;
                end else if (r_len == nfd_pkg::BYTE_ZERO ||
                             (r_len + i_byte) != nfd_pkg::BYTE_ZERO) begin
                    o_res.frame_done = 1'b1;
                    o_res.status     = nfd_pkg::ST_LCS_ERR;
                    n_phase          = nfd_pkg::PH_HUNT0;
                end else begin
                    n_left  = r_len;
                    n_sum   = '0;
                    n_phase = nfd_pkg::PH_BODY;
                end
            end
            nfd_pkg::PH_BODY: begin
                // TFI first, then command code, then payload
                if (body_pos == 8'd0) begin
                    n_tfi = i_byte;
                end else if (body_pos == 8'd1) begin
                    n_cmd = i_byte;
                end else begin
                    o_res.payload_byte  = i_byte;
                    o_res.payload_valid = 1'b1;
                end
                n_sum  = r_sum + i_byte;
                n_left = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    n_phase = nfd_pkg::PH_DCS;
                end
            end
            nfd_pkg::PH_DCS: begin
                n_sum = dcs_sum;
                if (dcs_sum != nfd_pkg::BYTE_ZERO) begin
                    o_res.frame_done = 1'b1;
                    o_res.status     = nfd_pkg::ST_DCS_ERR;
                    n_phase          = nfd_pkg::PH_HUNT0;
                end else begin
                    n_phase = nfd_pkg::PH_POST;
                end
            end
            nfd_pkg::PH_POST: begin
                o_res.frame_done = 1'b1;
                o_res.status     = (i_byte == nfd_pkg::BYTE_ZERO) ? nfd_pkg::ST_OK
                                                                  : nfd_pkg::ST_POST_ERR;
                n_phase          = nfd_pkg::PH_HUNT0;
            end
            default: begin
                // hunt for the first start byte, also for the unused code
                n_phase = (i_byte == nfd_pkg::BYTE_ZERO) ? nfd_pkg::PH_HUNTFF
                                                         : nfd_pkg::PH_HUNT0;
            end
        endcase
        o_res.frame_type = n_tfi;
        o_res.command    = n_cmd;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nfd_pkg::PH_HUNT0;
            r_len   <= '0;
            r_left  <= '0;
            r_sum   <= '0;
            r_tfi   <= '0;
            r_cmd   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_left  <= n_left;
            r_sum   <= n_sum;
            r_tfi   <= n_tfi;
            r_cmd   <= n_cmd;
        end
    end

endmodule

### rtl/nfd_out_reg.sv
// Result register stage of the deframer.
module nfd_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,   // a new result is offered
    input  nfd_pkg::t_result   i_res,
    output logic               o_adv,    // stage can take a result this cycle
    output logic               o_valid,
    input  logic               i_ready,
    output nfd_pkg::t_result   o_res
);

    logic             r_valid;
    nfd_pkg::t_result r_res;

    assign o_adv   = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_load;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_adv && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/nfc_frame_deframer_checksum.sv
// Top level of the information frame deframer with length and data checksum checks.
//
//  channel | dir | tdata                                   | tlast      | tuser
//  s       | in  | [7:0] rx_byte                           | -          | -
//  m       | out | [7:0] payload_byte, [15:8] frame_type,  | frame_done | payload_valid
//          |     | [23:16] command, [26:24] status         |            |
//
// Every byte gives one result beat; it passes the input register, then the parse logic, then the result register.
// One byte per cycle is sustained while m does not stall; the parse state updates in one pass per byte.
// Reset (i_rst_n low, synchronous) empties both stages and returns to the start code hunt.
// A stall on m holds the result; s keeps accepting while the input register can move.
`include "assert_macros.svh"

module nfc_frame_deframer_checksum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [nfd_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [nfd_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // [7:0] payload_byte,
                                                           // [15:8] frame_type,
                                                           // [23:16] command,
                                                           // [26:24] status
    output logic                              o_m_tlast,   // frame_done
    output logic                              o_m_tuser    // payload_valid
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             adv;
    logic             step;
    nfd_pkg::t_result step_res;
    nfd_pkg::t_result out_res;

    assign step = in_valid && adv;

    // Input register
    nfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    // Parse logic and frame state
    nfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (in_byte),
        .o_res   (step_res)
    );

    // Result register
    nfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_valid),
        .i_res   (step_res),
        .o_adv   (adv),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    // Pack result beat
    assign o_m_tdata = {5'd0, out_res.status, out_res.command,
                        out_res.frame_type, out_res.payload_byte};
    assign o_m_tlast = out_res.frame_done;
    assign o_m_tuser = out_res.payload_valid;

    // Checks
    `NFD_ASSERT(a_status_only_on_done, o_m_tvalid && !o_m_tlast |-> o_m_tdata[26:24] == nfd_pkg::ST_OK, "status set without frame end")
    `NFD_ASSERT(a_no_payload_on_done, o_m_tvalid |-> !(o_m_tuser && o_m_tlast), "payload beat also ends frame")
    `NFD_ASSERT(a_status_legal, o_m_tvalid |-> (o_m_tdata[26:24] == nfd_pkg::ST_OK || o_m_tdata[26:24] == nfd_pkg::ST_ACK || o_m_tdata[26:24] == nfd_pkg::ST_LCS_ERR || o_m_tdata[26:24] == nfd_pkg::ST_DCS_ERR || o_m_tdata[26:24] == nfd_pkg::ST_POST_ERR), "status code out of range")
    `NFD_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

### dv/nfc_frame_deframer_checksum_tb.sv
// Self-checking testbench for the information frame deframer: byte stream in, one result beat out.
`timescale 1ns / 100ps

module nfc_frame_deframer_checksum_tb;

    localparam int ITEMS_PER_PHASE = 285;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 300000;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic [nfd_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                            i_m_tready = 1'b0;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [nfd_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            o_m_tlast;
    logic                            o_m_tuser;

    // Stimulus and scoreboard storage
    logic [7:0]       rx_bytes_q[$];
    nfd_pkg::t_result expected_beats[$];

    int   tx_idle_pct    = 0;
    int   rx_idle_pct    = 0;
    int   idle_mode      = 0;
    int   mismatch_count = 0;
    bit   s_fired        = 1'b0;
    logic hold_off       = 1'b0;

    // Shadow parser state
    logic [2:0] parse_ph  = nfd_pkg::PH_HUNT0;
    logic [7:0] len_q     = '0;
    logic [7:0] left_q    = '0;
    logic [7:0] body_sum  = '0;
    logic [7:0] tfi_q     = '0;
    logic [7:0] cmd_q     = '0;

    nfc_frame_deframer_checksum dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] rx_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] payload_byte, [15:8] frame_type,
                                   // [23:16] command, [26:24] status
        .o_m_tlast  (o_m_tlast),   // frame_done
        .o_m_tuser  (o_m_tuser)    // payload_valid
    );

    // Clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reset held low from the start, released once
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Advance the shadow parser by one byte and return the result it gives
    function automatic nfd_pkg::t_result deframe_byte(input logic [7:0] b);
        nfd_pkg::t_result r;
        logic [7:0]       pos;
        logic [7:0]       lsum;
        r        = '0;
        r.status = nfd_pkg::ST_OK;
        case (parse_ph)
            nfd_pkg::PH_HUNTFF: begin
                if (b == nfd_pkg::BYTE_FF) begin
                    parse_ph = nfd_pkg::PH_LEN;
                    tfi_q    = '0;
                    cmd_q    = '0;
                    body_sum = '0;
                end else if (b == nfd_pkg::BYTE_ZERO) begin
                    parse_ph = nfd_pkg::PH_HUNTFF;
                end else begin
                    parse_ph = nfd_pkg::PH_HUNT0;
                end
            end
            nfd_pkg::PH_LEN: begin
                len_q    = b;
                parse_ph = nfd_pkg::PH_LCS;
            end
            nfd_pkg::PH_LCS: begin
                lsum = len_q + b;
                if (len_q == nfd_pkg::BYTE_ZERO && b == nfd_pkg::BYTE_FF) begin
                    r.frame_done = 1'b1;
                    r.status     = nfd_pkg::ST_ACK;
                    parse_ph     = nfd_pkg::PH_HUNT0;
                end else if (len_q == nfd_pkg::BYTE_ZERO || lsum != nfd_pkg::BYTE_ZERO) begin
                    r.frame_done = 1'b1;
                    r.status     = nfd_pkg::ST_LCS_ERR;
                    parse_ph     = nfd_pkg::PH_HUNT0;
                end else begin
                    left_q   = len_q;
                    body_sum = '0;
                    parse_ph = nfd_pkg::PH_BODY;
                end
            end
            nfd_pkg::PH_BODY: begin
                pos = len_q - left_q;
                if (pos == 8'd0) begin
                    tfi_q = b;
                end else if (pos == 8'd1) begin
                    cmd_q = b;
                end else begin
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                end
                body_sum = body_sum + b;
                left_q   = left_q - 8'd1;
                if (left_q == 8'd0) parse_ph = nfd_pkg::PH_DCS;
            end
            nfd_pkg::PH_DCS: begin
                body_sum = body_sum + b;
                if (body_sum != nfd_pkg::BYTE_ZERO) begin
                    r.frame_done = 1'b1;
                    r.status     = nfd_pkg::ST_DCS_ERR;
                    parse_ph     = nfd_pkg::PH_HUNT0;
                end else begin
                    parse_ph = nfd_pkg::PH_POST;
                end
            end
            nfd_pkg::PH_POST: begin
                r.frame_done = 1'b1;
                r.status     = (b == nfd_pkg::BYTE_ZERO) ? nfd_pkg::ST_OK
                                                         : nfd_pkg::ST_POST_ERR;
                parse_ph     = nfd_pkg::PH_HUNT0;
            end
            default: begin
                parse_ph = (b == nfd_pkg::BYTE_ZERO) ? nfd_pkg::PH_HUNTFF
                                                     : nfd_pkg::PH_HUNT0;
            end
        endcase
        r.frame_type = tfi_q;
        r.command    = cmd_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h, wanted %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Append one byte to the stimulus queue
    task automatic queue_rx_byte(input logic [7:0] val);
        rx_bytes_q = {rx_bytes_q, val};
    endtask

    // Append one frame with random content; mostly well formed, some broken
    task automatic queue_random_frame();
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         kind;
        int         cut;
        kind = int'($urandom_range(99));
        // line noise between frames
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) queue_rx_byte(8'($urandom));
        // extra zero ahead of the start code now and then
        if ($urandom_range(4) == 0) queue_rx_byte(nfd_pkg::BYTE_ZERO);
        queue_rx_byte(nfd_pkg::BYTE_ZERO);
        queue_rx_byte(nfd_pkg::BYTE_FF);
        if (kind < 8) begin
            // ACK frame
            queue_rx_byte(nfd_pkg::BYTE_ZERO);
            queue_rx_byte(nfd_pkg::BYTE_FF);
        end else if (kind < 14) begin
            // zero length without the ACK code
            queue_rx_byte(nfd_pkg::BYTE_ZERO);
            queue_rx_byte(8'($urandom_range(0, 254)));
        end else if (kind < 22) begin
            // length checksum off by a nonzero amount
            len = 8'($urandom_range(1, 255));
            queue_rx_byte(len);
            queue_rx_byte(8'(nfd_pkg::BYTE_ZERO - len + 8'($urandom_range(1, 255))));
        end else begin
            len = ($urandom_range(59) == 0) ? nfd_pkg::BYTE_FF : 8'($urandom_range(1, 10));
            cut = (kind < 30) ? int'($urandom_range(0, int'(len) - 1)) : int'(len);
            sum = nfd_pkg::BYTE_ZERO;
            queue_rx_byte(len);
            queue_rx_byte(8'(nfd_pkg::BYTE_ZERO - len));
            for (int i = 0; i < cut; i++) begin
                case ($urandom_range(7))
                    0:       b = nfd_pkg::BYTE_ZERO;
                    1:       b = nfd_pkg::BYTE_FF;
                    default: b = 8'($urandom);
                endcase
                sum = sum + b;
                queue_rx_byte(b);
            end
            // truncated frames stop here; the rest get DCS and postamble
            if (cut == int'(len)) begin
                if (kind < 40)
                    queue_rx_byte(8'(nfd_pkg::BYTE_ZERO - sum + 8'($urandom_range(1, 255))));
                else
                    queue_rx_byte(8'(nfd_pkg::BYTE_ZERO - sum));
                if (kind >= 40 && kind < 48)
                    queue_rx_byte(8'($urandom_range(1, 255)));
                else
                    queue_rx_byte(nfd_pkg::BYTE_ZERO);
            end
        end
    endtask

    // Sender: offers the next byte at the falling edge, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || s_fired)) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= rx_bytes_q.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, forced low during the hold-off
    always @(negedge i_clk) begin
        i_m_tready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (idle_mode == 2);
        repeat (40) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Monitor: check result beats, then predict for each accepted input beat
    always @(posedge i_clk) begin
        nfd_pkg::t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing pending, tdata", o_m_tdata, '0);
                end else begin
                    want = expected_beats.pop_front();
                    if (o_m_tdata[7:0] !== want.payload_byte)
                        report_mismatch("payload_byte", 32'(o_m_tdata[7:0]),
                                        32'(want.payload_byte));
                    if (o_m_tuser !== want.payload_valid)
                        report_mismatch("payload_valid", 32'(o_m_tuser),
                                        32'(want.payload_valid));
                    if (o_m_tdata[15:8] !== want.frame_type)
                        report_mismatch("frame_type", 32'(o_m_tdata[15:8]),
                                        32'(want.frame_type));
                    if (o_m_tdata[23:16] !== want.command)
                        report_mismatch("command", 32'(o_m_tdata[23:16]),
                                        32'(want.command));
                    if (o_m_tlast !== want.frame_done)
                        report_mismatch("frame_done", 32'(o_m_tlast),
                                        32'(want.frame_done));
                    if (o_m_tdata[26:24] !== want.status)
                        report_mismatch("status", 32'(o_m_tdata[26:24]),
                                        32'(want.status));
                end
            end
            s_fired = i_s_tvalid && o_s_tready;
            if (s_fired) expected_beats = {expected_beats, deframe_byte(i_s_tdata)};
        end else begin
            s_fired = 1'b0;
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // Stimulus: directed frames, then random frames over three idling patterns
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        for (int ph = 0; ph < 3; ph++) begin
            idle_mode = ph;
            case (ph)
                0:       begin tx_idle_pct = 34; rx_idle_pct = 88; end
                1:       begin tx_idle_pct = 88; rx_idle_pct = 34; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            if (ph == 0) begin
                // repeated zeros before the start code, then an ACK
                rx_bytes_q = {8'h00, 8'h00, 8'hff, 8'h00, 8'hff};
                // after the ACK the hunt needs a zero before the start code, so these bytes start no frame
                rx_bytes_q = {rx_bytes_q, 8'hff, 8'h00, 8'h12};
                // length one: TFI only, good DCS and postamble
                rx_bytes_q = {rx_bytes_q, 8'h00, 8'hff, 8'h01, 8'hff, 8'hd4, 8'h2c, 8'h00};
                // length three with extreme bytes, bad postamble
                rx_bytes_q = {rx_bytes_q, 8'h00, 8'hff, 8'h03, 8'hfd, 8'hff, 8'h00,
                              8'h80, 8'h81, 8'hff};
            end
            while (rx_bytes_q.size() < ITEMS_PER_PHASE) queue_random_frame();
            wait (rx_bytes_q.size() == 0 && !i_s_tvalid);
            wait (expected_beats.size() == 0);
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
